// ===== src/pads_pkg.sv =====
// ----------------------------------------------------------------------------
// pads_pkg: shared types and constants for the phase angle dimmer sequencer
// Field widths, reset values, action and register codes, and the words that
// travel between the front mapper, the queues and the back state engine.
// ----------------------------------------------------------------------------
package pads_pkg;

	// field widths
	localparam int ACT_W     = 2;
	localparam int POT_W     = 12;
	localparam int BRIGHT_W  = 7;
	localparam int DELAY_W   = 16;
	localparam int LEVEL_W   = 8;
	localparam int RAMP_W    = 2;
	localparam int OUT_SLOTS = 3;

	// pot full scale, divisor of the pot mapping
	localparam int POT_FULL = 4095;

	// lamp count default and level after reset
	localparam int                 LAMP_COUNT_DEF = 3;
	localparam logic [LEVEL_W-1:0] LAMP_RESET     = 8'd100;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_LOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DELAY_LOW   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DELAY_HIGH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OFF_LEVEL   = 3'd4;

	localparam logic [BRIGHT_W-1:0] BRIGHT_LOW_RST  = 7'd85;
	localparam logic [BRIGHT_W-1:0] BRIGHT_HIGH_RST = 7'd35;
	localparam logic [DELAY_W-1:0]  DELAY_LOW_RST   = 16'd100;
	localparam logic [DELAY_W-1:0]  DELAY_HIGH_RST  = 16'd700;
	localparam logic [LEVEL_W-1:0]  OFF_LEVEL_RST   = 8'd100;

	// event kinds
	localparam logic [ACT_W-1:0] ACT_TICK     = 2'd0;
	localparam logic [ACT_W-1:0] ACT_ZERO     = 2'd1;
	localparam logic [ACT_W-1:0] ACT_PRESENCE = 2'd2;

	// queue depths
	localparam int JOB_DEPTH = 8;
	localparam int RES_DEPTH = 2;

	typedef struct packed {
		logic [BRIGHT_W-1:0] bright_low;
		logic [BRIGHT_W-1:0] bright_high;
		logic [DELAY_W-1:0]  delay_low;
		logic [DELAY_W-1:0]  delay_high;
		logic [LEVEL_W-1:0]  off_level;
	} cfg_t;

	// classified event with its mapped pot value (delay on a tick, else target)
	typedef struct packed {
		logic [ACT_W-1:0]   action;
		logic [DELAY_W-1:0] mapped;
	} job_t;

	typedef struct packed {
		logic [OUT_SLOTS-1:0]              fire;
		logic [OUT_SLOTS-1:0][LEVEL_W-1:0] level;
		logic [RAMP_W-1:0]                 ramp;
		logic                              presence;
		logic [LEVEL_W-1:0]                target;
	} res_t;

endpackage

// ===== src/phase_angle_dimmer_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// phase_angle_dimmer_sequencer_top: three-lamp triac phase-angle dimmer
// Front maps the pots, a job queue decouples it from the state engine, and a
// result queue holds finished words until they are popped.
// ----------------------------------------------------------------------------
//
// channel  direction  handshake             word
// -------  ---------  --------------------  -------------------------------------
// events   in         push / full           action, delay_pot, brightness_pot
// results  out        empty / pop           fire_lamp_*, level_*, ramping_lamp,
//                                           presence_on, fade_target
// config   in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// one event per cycle sustained while full is low; a result passes three
// mapping stages in front, the job queue and one state update in back
// the state engine updates all lamp state together for each word
// full rises when the job queue plus words in the mapping pipe reach its depth
// reset is asynchronous; no clearing pass, the block takes events right away
// cfg_ready is always high; config writes go straight into the registers
//
module phase_angle_dimmer_sequencer_top #(
	parameter int LAMP_COUNT = pads_pkg::LAMP_COUNT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// events
	input  logic                              push,
	output logic                              full,
	input  logic [pads_pkg::ACT_W-1:0]        action,
	input  logic [pads_pkg::POT_W-1:0]        delay_pot,
	input  logic [pads_pkg::POT_W-1:0]        brightness_pot,
	// results
	output logic                              empty,
	input  logic                              pop,
	output logic                              fire_lamp_one,
	output logic                              fire_lamp_two,
	output logic                              fire_lamp_three,
	output logic [pads_pkg::LEVEL_W-1:0]      level_one,
	output logic [pads_pkg::LEVEL_W-1:0]      level_two,
	output logic [pads_pkg::LEVEL_W-1:0]      level_three,
	output logic [pads_pkg::RAMP_W-1:0]       ramping_lamp,
	output logic                              presence_on,
	output logic [pads_pkg::LEVEL_W-1:0]      fade_target,
	// configuration
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [pads_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pads_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int JLW = $clog2(pads_pkg::JOB_DEPTH+1);
	localparam int RLW = $clog2(pads_pkg::RES_DEPTH+1);
	localparam int JW  = $bits(pads_pkg::job_t);
	localparam int RW  = $bits(pads_pkg::res_t);

	pads_pkg::cfg_t cfg_q;

	logic           job_wr;
	pads_pkg::job_t job_w;
	logic           job_rd;
	logic [JW-1:0]  job_rdata;
	pads_pkg::job_t job_r;
	logic           job_empty;
	logic           job_full;
	logic [JLW-1:0] job_level;

	logic           res_wr;
	pads_pkg::res_t res_w;
	logic           res_rd;
	logic [RW-1:0]  res_rdata;
	pads_pkg::res_t res_r;
	logic           res_full;
	logic [RLW-1:0] res_level;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bright_low  <= pads_pkg::BRIGHT_LOW_RST;
			cfg_q.bright_high <= pads_pkg::BRIGHT_HIGH_RST;
			cfg_q.delay_low   <= pads_pkg::DELAY_LOW_RST;
			cfg_q.delay_high  <= pads_pkg::DELAY_HIGH_RST;
			cfg_q.off_level   <= pads_pkg::OFF_LEVEL_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pads_pkg::REG_BRIGHT_LOW:  cfg_q.bright_low  <= cfg_data[pads_pkg::BRIGHT_W-1:0];
				pads_pkg::REG_BRIGHT_HIGH: cfg_q.bright_high <= cfg_data[pads_pkg::BRIGHT_W-1:0];
				pads_pkg::REG_DELAY_LOW:   cfg_q.delay_low   <= cfg_data[pads_pkg::DELAY_W-1:0];
				pads_pkg::REG_DELAY_HIGH:  cfg_q.delay_high  <= cfg_data[pads_pkg::DELAY_W-1:0];
				pads_pkg::REG_OFF_LEVEL:   cfg_q.off_level   <= cfg_data[pads_pkg::LEVEL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// front: intake and pot mapping
	pads_front #(
		.JOB_DEPTH (pads_pkg::JOB_DEPTH)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.push           (push),
		.full           (full),
		.action         (action),
		.delay_pot      (delay_pot),
		.brightness_pot (brightness_pot),
		.job_level      (job_level),
		.job_wr         (job_wr),
		.job            (job_w)
	);

	// job queue between front and back
	pads_queue #(
		.W     (JW),
		.DEPTH (pads_pkg::JOB_DEPTH)
	) u_job_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (job_wr),
		.wr_data (job_w),
		.rd_en   (job_rd),
		.rd_data (job_rdata),
		.empty   (job_empty),
		.full    (job_full),
		.level   (job_level)
	);

	assign job_r = pads_pkg::job_t'(job_rdata);

	// back: state engine
	pads_back #(
		.LAMP_COUNT (LAMP_COUNT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job_empty (job_empty),
		.job       (job_r),
		.job_rd    (job_rd),
		.res_full  (res_full),
		.res_wr    (res_wr),
		.res       (res_w)
	);

	// result queue
	assign res_rd = pop && !empty;

	pads_queue #(
		.W     (RW),
		.DEPTH (pads_pkg::RES_DEPTH)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_wr),
		.wr_data (res_w),
		.rd_en   (res_rd),
		.rd_data (res_rdata),
		.empty   (empty),
		.full    (res_full),
		.level   (res_level)
	);

	assign res_r = pads_pkg::res_t'(res_rdata);

	// result word to ports
	assign fire_lamp_one   = res_r.fire[0];
	assign fire_lamp_two   = res_r.fire[1];
	assign fire_lamp_three = res_r.fire[2];
	assign level_one       = res_r.level[0];
	assign level_two       = res_r.level[1];
	assign level_three     = res_r.level[2];
	assign ramping_lamp    = res_r.ramp;
	assign presence_on     = res_r.presence;
	assign fade_target     = res_r.target;

	// the credit check keeps the job queue from ever filling past its depth
	a_job_credit: assert property (@(posedge clk) disable iff (!arst_n)
		job_full |-> full)
		else $error("job queue full while intake still open");

	// result level agrees with the empty flag
	a_res_level: assert property (@(posedge clk) disable iff (!arst_n)
		empty == (res_level == '0))
		else $error("result queue level and empty flag disagree");

endmodule

// ===== src/pads_queue.sv =====
// ----------------------------------------------------------------------------
// pads_queue: small synchronous queue
// Register array with write and read pointers and a fill level; the head
// word is shown combinationally.
// ----------------------------------------------------------------------------
module pads_queue #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [W-1:0]               wr_data,
	input  logic                       rd_en,
	output logic [W-1:0]               rd_data,
	output logic                       empty,
	output logic                       full,
	output logic [$clog2(DEPTH+1)-1:0] level
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LW = $clog2(DEPTH+1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [LW-1:0] level_q;

	// storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				level_q <= level_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	assign rd_data = mem_q[rd_ptr_q];
	assign empty   = (level_q == '0);
	assign full    = (level_q == LW'(DEPTH));
	assign level   = level_q;

	// no overrun, no underrun
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (level_q != LW'(DEPTH)))
		else $error("queue written while full");

	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (level_q != '0))
		else $error("queue read while empty");

endmodule

// ===== src/pads_front.sv =====
// ----------------------------------------------------------------------------
// pads_front: event intake and pot mapping
// Takes events, picks the pot that matters (delay on a tick, brightness
// otherwise) and maps it through low + pot * (high - low) / 4095 in three
// stages: multiply, magnitude and quotient estimate, correction and offset.
// ----------------------------------------------------------------------------
module pads_front #(
	parameter int JOB_DEPTH = pads_pkg::JOB_DEPTH
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  pads_pkg::cfg_t                       cfg,
	input  logic                                 push,
	output logic                                 full,
	input  logic [pads_pkg::ACT_W-1:0]           action,
	input  logic [pads_pkg::POT_W-1:0]           delay_pot,
	input  logic [pads_pkg::POT_W-1:0]           brightness_pot,
	input  logic [$clog2(JOB_DEPTH+1)-1:0]       job_level,
	output logic                                 job_wr,
	output pads_pkg::job_t                       job
);

	localparam int LW   = $clog2(JOB_DEPTH+1);
	localparam int PW   = pads_pkg::POT_W;
	localparam int DW   = pads_pkg::DELAY_W;
	localparam int SPW  = DW + 1;
	localparam int PRW  = PW + 1 + SPW;
	localparam int MGW  = PW + DW;
	localparam int BW   = pads_pkg::BRIGHT_W;
	localparam int SHF  = PW;

	logic accept;

	logic                           v_s1, v_s2, v_s3;
	logic [pads_pkg::ACT_W-1:0]     act_s1, act_s2, act_s3;
	logic [PW-1:0]                  pot_s1;
	logic signed [PRW-1:0]          prod_s2;
	logic [MGW-1:0]                 mag_s3;
	logic [DW-1:0]                  q0_s3;
	logic                           neg_s3;

	logic [LW+1:0]                  committed;

	logic [SPW-1:0]                 lo_x, hi_x;
	logic signed [SPW-1:0]          span;
	logic signed [PW:0]             pot_sx;
	logic signed [PRW-1:0]          prod_c;

	logic [PRW-1:0]                 negp;
	logic [MGW-1:0]                 mag_c;
	logic [MGW:0]                   est_sum;

	logic [MGW-1:0]                 q_times;
	logic [MGW-1:0]                 rem;
	logic [DW-1:0]                  quot;
	logic [DW-1:0]                  lo16;

	// credit check: queued words plus words still in the pipe
	assign committed = {2'b00, job_level} + (LW+2)'(v_s1) + (LW+2)'(v_s2) + (LW+2)'(v_s3);
	assign full      = (committed >= (LW+2)'(JOB_DEPTH));
	assign accept    = push && !full;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// stage 1: capture event, keep only the pot this event needs
	always_ff @(posedge clk) begin
		act_s1 <= action;
		pot_s1 <= (action == pads_pkg::ACT_TICK) ? delay_pot : brightness_pot;
	end

	// stage 2: span and signed product
	always_comb begin
		if (act_s1 == pads_pkg::ACT_TICK) begin
			lo_x = {1'b0, cfg.delay_low};
			hi_x = {1'b0, cfg.delay_high};
		end else begin
			lo_x = {(SPW-BW)'(0), cfg.bright_low};
			hi_x = {(SPW-BW)'(0), cfg.bright_high};
		end
		span   = signed'(hi_x - lo_x);
		pot_sx = signed'({1'b0, pot_s1});
		prod_c = PRW'(pot_sx) * PRW'(span);
	end

	always_ff @(posedge clk) begin
		act_s2  <= act_s1;
		prod_s2 <= prod_c;
	end

	// stage 3: magnitude and quotient estimate, x/4095 ~ (x + x>>12 + x>>24) >> 12
	always_comb begin
		negp    = -prod_s2;
		mag_c   = prod_s2[PRW-1] ? negp[MGW-1:0] : prod_s2[MGW-1:0];
		est_sum = {1'b0, mag_c} + (MGW+1)'(mag_c >> SHF) + (MGW+1)'(mag_c >> (2*SHF));
	end

	always_ff @(posedge clk) begin
		act_s3 <= act_s2;
		neg_s3 <= prod_s2[PRW-1];
		mag_s3 <= mag_c;
		q0_s3  <= est_sum[MGW-1:SHF];
	end

	// stage 4: estimate is low by at most one; fix it, restore sign, add offset
	always_comb begin
		q_times = {q0_s3, (MGW-DW)'(0)} - {(MGW-DW)'(0), q0_s3};
		rem     = mag_s3 - q_times;
		quot    = q0_s3 + DW'(rem >= MGW'(pads_pkg::POT_FULL));
		lo16    = (act_s3 == pads_pkg::ACT_TICK) ? cfg.delay_low
		                                         : {(DW-BW)'(0), cfg.bright_low};
		job.action = act_s3;
		job.mapped = neg_s3 ? (lo16 - quot) : (lo16 + quot);
	end

	assign job_wr = v_s3;

endmodule

// ===== src/pads_back.sv =====
// ----------------------------------------------------------------------------
// pads_back: dimmer state engine
// Applies one mapped event per cycle, while the job queue has a word and the
// result queue has room, to the phase and delay counters, the lamp levels, the
// ramp sequence and presence, and builds the result word.
module pads_back #(
	parameter int LAMP_COUNT = pads_pkg::LAMP_COUNT_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  pads_pkg::cfg_t cfg,
	input  logic           job_empty,
	input  pads_pkg::job_t job,
	output logic           job_rd,
	input  logic           res_full,
	output logic           res_wr,
	output pads_pkg::res_t res
);

	localparam int CW  = $clog2(LAMP_COUNT+1);
	localparam int LVW = pads_pkg::LEVEL_W;
	localparam int DW  = pads_pkg::DELAY_W;
	localparam int NS  = pads_pkg::OUT_SLOTS;

	logic go;

	logic [LVW-1:0] phase_q;
	logic [DW-1:0]  dcnt_q;
	logic [LVW-1:0] lvl_q [LAMP_COUNT];
	logic [CW-1:0]  cur_q;
	logic           pres_q;
	logic [LVW-1:0] tgt_q;

	logic [LVW-1:0]        phase_n;
	logic [DW-1:0]         dcnt_n;
	logic [DW-1:0]         dinc;
	logic [LVW-1:0]        lvl_n [LAMP_COUNT];
	logic [LAMP_COUNT-1:0] fire_n;
	logic [CW-1:0]         cur_n;
	logic                  pres_n;
	logic [LVW-1:0]        tgt_n;
	logic [LVW-1:0]        cur_lv;
	logic                  cur_ok;
	logic                  step;
	logic                  lower, raise, advance;

	logic [NS-1:0]          fire_o;
	logic [NS-1:0][LVW-1:0] lvl_o;
	logic [CW+1:0]          cur_x;

	assign go     = !job_empty && !res_full;
	assign job_rd = go;
	assign res_wr = go;

	// next state for the event at the queue head
	always_comb begin
		phase_n = phase_q;
		dcnt_n  = dcnt_q;
		dinc    = dcnt_q + 1'b1;
		cur_n   = cur_q;
		pres_n  = pres_q;
		tgt_n   = tgt_q;
		step    = 1'b0;
		lower   = 1'b0;
		raise   = 1'b0;
		advance = 1'b0;
		fire_n  = '0;
		cur_lv  = '0;
		for (int i = 0; i < LAMP_COUNT; i++) begin
			lvl_n[i] = lvl_q[i];
			if (cur_q == CW'(i)) begin
				cur_lv = lvl_q[i];
			end
		end
		cur_ok = (cur_q < CW'(LAMP_COUNT));

		case (job.action)
			pads_pkg::ACT_TICK: begin
				for (int i = 0; i < LAMP_COUNT; i++) begin
					fire_n[i] = (phase_q == lvl_q[i]);
				end
				phase_n = phase_q + 1'b1;
				if (dinc >= job.mapped) begin
					dcnt_n = '0;
					step   = cur_ok;
				end else begin
					dcnt_n = dinc;
				end
			end
			pads_pkg::ACT_ZERO: begin
				phase_n = '0;
				tgt_n   = job.mapped[LVW-1:0];
			end
			pads_pkg::ACT_PRESENCE: begin
				pres_n = !pres_q;
				cur_n  = '0;
				tgt_n  = job.mapped[LVW-1:0];
			end
			default: begin
				tgt_n = job.mapped[LVW-1:0];
			end
		endcase

		// ramp step on the current lamp
		if (step) begin
			if (pres_q) begin
				if (cur_lv > tgt_q) lower = 1'b1;
				else                advance = 1'b1;
			end else begin
				if (cur_lv < cfg.off_level) raise = 1'b1;
				else                        advance = 1'b1;
			end
		end
		for (int i = 0; i < LAMP_COUNT; i++) begin
			if (cur_q == CW'(i)) begin
				if (lower) lvl_n[i] = cur_lv - 1'b1;
				if (raise) lvl_n[i] = cur_lv + 1'b1;
			end
		end
		if (advance) begin
			cur_n = cur_q + 1'b1;
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			dcnt_q  <= '0;
			cur_q   <= '0;
			pres_q  <= 1'b0;
			tgt_q   <= '0;
			for (int i = 0; i < LAMP_COUNT; i++) begin
				lvl_q[i] <= pads_pkg::LAMP_RESET;
			end
		end else if (go) begin
			phase_q <= phase_n;
			dcnt_q  <= dcnt_n;
			cur_q   <= cur_n;
			pres_q  <= pres_n;
			tgt_q   <= tgt_n;
			for (int i = 0; i < LAMP_COUNT; i++) begin
				lvl_q[i] <= lvl_n[i];
			end
		end
	end

	// output slots; slots past the lamp count stay dark at the reset level
	for (genvar s = 0; s < NS; s++) begin : g_slot
		if (s < LAMP_COUNT) begin : g_lamp
			assign fire_o[s] = fire_n[s];
			assign lvl_o[s]  = lvl_n[s];
		end else begin : g_none
			assign fire_o[s] = 1'b0;
			assign lvl_o[s]  = pads_pkg::LAMP_RESET;
		end
	end

	assign cur_x = {2'b00, cur_n};

	always_comb begin
		res.fire     = fire_o;
		res.level    = lvl_o;
		res.ramp     = cur_x[pads_pkg::RAMP_W-1:0];
		res.presence = pres_n;
		res.target   = tgt_n;
	end

	// sequence index never runs past the finished mark
	a_cur_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q <= CW'(LAMP_COUNT))
		else $error("lamp index past end of sequence");

	// presence edge flips presence and restarts the sequence
	a_presence_restart: assert property (@(posedge clk) disable iff (!arst_n)
		go && (job.action == pads_pkg::ACT_PRESENCE)
		|=> (cur_q == '0) && (pres_q != $past(pres_q)))
		else $error("presence edge did not restart the sequence");

	// non-tick events never fire and leave the delay counter alone
	a_nontick_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		go && (job.action != pads_pkg::ACT_TICK)
		|-> (res.fire == '0) ##1 $stable(dcnt_q))
		else $error("non-tick event fired a lamp or moved the delay counter");

endmodule

// ===== test/phase_angle_dimmer_sequencer_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// phase_angle_dimmer_sequencer_top_test: self-checking bench for the dimmer
// A short table of directed events is followed by mains-like runs of phase
// ticks under several register settings. Each accepted event is fed to a
// local model of the lamp sequencer. Each popped word is compared field by
// field with the oldest expected word. Both sides idle at random, and the
// result side also holds off long enough to fill the block.
// ----------------------------------------------------------------------------
module phase_angle_dimmer_sequencer_top_test;
	import pads_pkg::*;

	localparam int LAMPS = LAMP_COUNT_DEF;
	localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LAST = CFG_IDX_W'((1 << CFG_IDX_W) - 1);
	localparam int N_DIRECTED = 13;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES = 64;

	typedef struct packed {
		logic [ACT_W-1:0] act;
		logic [POT_W-1:0] dpot;
		logic [POT_W-1:0] bpot;
		logic             known;
		res_t             want;
	} directed_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic push;
	logic full;
	logic [ACT_W-1:0] action;
	logic [POT_W-1:0] delay_pot;
	logic [POT_W-1:0] brightness_pot;
	logic empty;
	logic pop;
	logic fire_lamp_one;
	logic fire_lamp_two;
	logic fire_lamp_three;
	logic [LEVEL_W-1:0] level_one;
	logic [LEVEL_W-1:0] level_two;
	logic [LEVEL_W-1:0] level_three;
	logic [RAMP_W-1:0] ramping_lamp;
	logic presence_on;
	logic [LEVEL_W-1:0] fade_target;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	phase_angle_dimmer_sequencer_top dut (.*);

	always #6 clk = ~clk;

	// model copy of the registers
	logic [BRIGHT_W-1:0] bright_low;
	logic [BRIGHT_W-1:0] bright_high;
	logic [DELAY_W-1:0]  delay_low;
	logic [DELAY_W-1:0]  delay_high;
	logic [LEVEL_W-1:0]  off_lvl;

	// model copy of the sequencer state
	logic [LEVEL_W-1:0] phase_cnt;
	logic [DELAY_W-1:0] delay_cnt;
	logic [LEVEL_W-1:0] lamp_lvl [OUT_SLOTS];
	logic [7:0]         cur_lamp;
	logic               presence;
	logic [LEVEL_W-1:0] target;

	res_t pending_words [$];
	directed_row_t directed [N_DIRECTED];
	logic [CFG_DATA_W-1:0] setting [5];
	logic [CFG_IDX_W-1:0] reg_order [5];

	int fail_count = 0;
	int events_sent = 0;
	int words_checked = 0;
	int lamp_fires = 0;
	int full_stalls = 0;
	bit send_steady = 1'b0;

	// pot mapping: signed multiply, divide truncating toward zero
	function automatic logic [31:0] map_pot(input logic [POT_W-1:0] pot,
			input logic [DELAY_W-1:0] lo, input logic [DELAY_W-1:0] hi);
		longint span;
		longint prod;
		longint q;
		span = longint'(hi) - longint'(lo);
		prod = longint'(pot) * span;
		q = prod / POT_FULL;
		return 32'(q + longint'(lo));
	endfunction

	function automatic void apply_setting(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_BRIGHT_LOW: bright_low = data[BRIGHT_W-1:0];
			REG_BRIGHT_HIGH: bright_high = data[BRIGHT_W-1:0];
			REG_DELAY_LOW: delay_low = data;
			REG_DELAY_HIGH: delay_high = data;
			REG_OFF_LEVEL: off_lvl = data[LEVEL_W-1:0];
			default: ;
		endcase
	endfunction

	// one fade step on the current lamp
	function automatic void fade_step();
		if (cur_lamp < LAMPS) begin
			if (presence) begin
				if (lamp_lvl[cur_lamp] > target)
					lamp_lvl[cur_lamp] = lamp_lvl[cur_lamp] - 1'b1;
				else
					cur_lamp = cur_lamp + 1'b1;
			end else begin
				if (lamp_lvl[cur_lamp] < off_lvl)
					lamp_lvl[cur_lamp] = lamp_lvl[cur_lamp] + 1'b1;
				else
					cur_lamp = cur_lamp + 1'b1;
			end
		end
	endfunction

	// advance the sequencer model by one event and return its word
	function automatic res_t sequence_event(input logic [ACT_W-1:0] act,
			input logic [POT_W-1:0] dpot, input logic [POT_W-1:0] bpot);
		res_t r;
		logic [31:0] mapped;
		int i;
		r = '0;
		if (act == ACT_TICK) begin
			for (i = 0; i < OUT_SLOTS; i++)
				if (i < LAMPS && phase_cnt == lamp_lvl[i])
					r.fire[i] = 1'b1;
			phase_cnt = phase_cnt + 1'b1;
			delay_cnt = delay_cnt + 1'b1;
			mapped = map_pot(dpot, delay_low, delay_high);
			if (delay_cnt >= mapped[DELAY_W-1:0]) begin
				fade_step();
				delay_cnt = '0;
			end
		end else begin
			if (act == ACT_ZERO) begin
				phase_cnt = '0;
			end else if (act == ACT_PRESENCE) begin
				presence = !presence;
				cur_lamp = '0;
			end
			mapped = map_pot(bpot, DELAY_W'(bright_low), DELAY_W'(bright_high));
			target = mapped[LEVEL_W-1:0];
		end
		for (i = 0; i < OUT_SLOTS; i++)
			r.level[i] = lamp_lvl[i];
		r.ramp = cur_lamp[RAMP_W-1:0];
		r.presence = presence;
		r.target = target;
		return r;
	endfunction

	// word with all lamps at reset level and no step taken yet
	function automatic res_t idle_word(input logic pres, input logic [LEVEL_W-1:0] tgt);
		res_t r;
		r = '0;
		r.level = {OUT_SLOTS{LAMP_RESET}};
		r.presence = pres;
		r.target = tgt;
		return r;
	endfunction

	function automatic logic [POT_W-1:0] pick_pot();
		logic [POT_W-1:0] v;
		case ($urandom_range(0, 9))
			0: v = '0;
			1: v = '1;
			default: v = POT_W'($urandom_range(0, POT_FULL));
		endcase
		return v;
	endfunction

	// offer one event word and record its expected result on acceptance
	task automatic offer(input logic [ACT_W-1:0] act, input logic [POT_W-1:0] dpot,
			input logic [POT_W-1:0] bpot, input logic known, input res_t want);
		int gap;
		res_t predicted;
		if ($urandom_range(0, 39) == 0)
			send_steady = !send_steady;
		gap = send_steady ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		action <= act;
		delay_pot <= dpot;
		brightness_pot <= bpot;
		@(posedge clk);
		while (full) begin
			full_stalls++;
			@(posedge clk);
		end
		predicted = sequence_event(act, dpot, bpot);
		pending_words.push_back(known ? want : predicted);
		events_sent++;
	endtask

	// stop sending and let every expected word come back
	task automatic drain();
		push <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write the five registers from setting[], optionally poking a spare index
	task automatic load_settings(input bit poke_spare);
		int i;
		for (i = 0; i < 6; i++) begin
			if (i == 5 && !poke_spare)
				break;
			cfg_valid <= 1'b1;
			if (i == 5) begin
				cfg_index <= CFG_IDX_W'($urandom_range(REG_OFF_LEVEL + 1, REG_LAST));
				cfg_data <= CFG_DATA_W'($urandom_range(0, 16'hFFFF));
			end else begin
				cfg_index <= reg_order[i];
				cfg_data <= setting[i];
			end
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			apply_setting(cfg_index, cfg_data);
		end
		cfg_valid <= 1'b0;
	endtask

	// mains-like traffic: zero crossing, then a run of ticks with some noise
	task automatic mains_runs(input int count);
		int sent;
		int run_len;
		int k;
		int pick;
		logic [ACT_W-1:0] act;
		sent = 0;
		while (sent < count) begin
			offer(ACT_ZERO, pick_pot(), pick_pot(), 1'b0, '0);
			sent++;
			run_len = $urandom_range(20, 260);
			for (k = 0; k < run_len && sent < count; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < 3)
					act = ACT_PRESENCE;
				else if (pick < 5)
					act = ACT_SPARE;
				else if (pick < 7)
					act = ACT_W'($urandom_range(0, 3));
				else
					act = ACT_TICK;
				offer(act, pick_pot(), pick_pot(), 1'b0, '0);
				sent++;
			end
		end
	endtask

	task automatic compare_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			fail_count++;
			$display("%0t ns: %s mismatch, expected %0d, got %0d",
				$time, name, want, got);
		end
	endtask

	// result side: random pops, long hold-offs, compare against oldest word
	initial begin : result_side
		int gap;
		bit steady;
		res_t got;
		res_t want;
		steady = 1'b0;
		pop = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if ($urandom_range(0, 31) == 0)
				steady = !steady;
			gap = steady ? 0 : $urandom_range(0, 3);
			if (words_checked == 300 || words_checked == 700)
				gap = HOLD_CYCLES;
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty)
				@(posedge clk);
			got.fire = {fire_lamp_three, fire_lamp_two, fire_lamp_one};
			got.level[0] = level_one;
			got.level[1] = level_two;
			got.level[2] = level_three;
			got.ramp = ramping_lamp;
			got.presence = presence_on;
			got.target = fade_target;
			if (pending_words.size() == 0) begin
				fail_count++;
				$display("%0t ns: word popped with none expected", $time);
			end else begin
				want = pending_words.pop_front();
				compare_field("fire_lamp_one", 16'(want.fire[0]), 16'(got.fire[0]));
				compare_field("fire_lamp_two", 16'(want.fire[1]), 16'(got.fire[1]));
				compare_field("fire_lamp_three", 16'(want.fire[2]), 16'(got.fire[2]));
				compare_field("level_one", 16'(want.level[0]), 16'(got.level[0]));
				compare_field("level_two", 16'(want.level[1]), 16'(got.level[1]));
				compare_field("level_three", 16'(want.level[2]), 16'(got.level[2]));
				compare_field("ramping_lamp", 16'(want.ramp), 16'(got.ramp));
				compare_field("presence_on", 16'(want.presence), 16'(got.presence));
				compare_field("fade_target", 16'(want.target), 16'(got.target));
				lamp_fires += $countones(want.fire);
				words_checked++;
			end
		end
	end

	// overall time limit
	initial begin
		#5000000;
		$display("Some tests failed");
		$finish;
	end

	// reset, directed table, then random phases under several settings
	initial begin : event_side
		int i;
		arst_n = 1'b0;
		push = 1'b0;
		action = ACT_TICK;
		delay_pot = '0;
		brightness_pot = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_BRIGHT_LOW;
		cfg_data = '0;

		reg_order[0] = REG_BRIGHT_LOW;
		reg_order[1] = REG_BRIGHT_HIGH;
		reg_order[2] = REG_DELAY_LOW;
		reg_order[3] = REG_DELAY_HIGH;
		reg_order[4] = REG_OFF_LEVEL;

		bright_low = BRIGHT_LOW_RST;
		bright_high = BRIGHT_HIGH_RST;
		delay_low = DELAY_LOW_RST;
		delay_high = DELAY_HIGH_RST;
		off_lvl = OFF_LEVEL_RST;
		phase_cnt = '0;
		delay_cnt = '0;
		for (i = 0; i < OUT_SLOTS; i++)
			lamp_lvl[i] = LAMP_RESET;
		cur_lamp = '0;
		presence = 1'b0;
		target = '0;

		// directed events under reset settings
		directed[0] = '{ACT_TICK, 12'd0, 12'd0, 1'b1, idle_word(1'b0, 8'd0)};
		directed[1] = '{ACT_ZERO, 12'd4095, 12'd0, 1'b1, idle_word(1'b0, 8'd85)};
		directed[2] = '{ACT_ZERO, 12'd0, 12'd4095, 1'b1, idle_word(1'b0, 8'd35)};
		directed[3] = '{ACT_SPARE, 12'd4095, 12'd4095, 1'b1, idle_word(1'b0, 8'd35)};
		// negative span, quotient truncates toward zero
		directed[4] = '{ACT_SPARE, 12'd0, 12'd2048, 1'b0, '0};
		directed[5] = '{ACT_PRESENCE, 12'd0, 12'd0, 1'b1, idle_word(1'b1, 8'd85)};
		directed[6] = '{ACT_TICK, 12'd4095, 12'd4095, 1'b0, '0};
		directed[7] = '{ACT_TICK, 12'd2048, 12'd1, 1'b0, '0};
		directed[8] = '{ACT_PRESENCE, 12'd4095, 12'd4095, 1'b0, '0};
		directed[9] = '{ACT_TICK, 12'd1, 12'd4095, 1'b0, '0};
		directed[10] = '{ACT_ZERO, 12'd2730, 12'd1365, 1'b0, '0};
		directed[11] = '{ACT_SPARE, 12'd0, 12'd0, 1'b0, '0};
		directed[12] = '{ACT_TICK, 12'd0, 12'd0, 1'b0, '0};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < N_DIRECTED; i++)
			offer(directed[i].act, directed[i].dpot, directed[i].bpot,
				directed[i].known, directed[i].want);
		drain();

		// extremes: full target range, a fade step on every tick, off at 255
		setting = '{16'd0, 16'd127, 16'd0, 16'd0, 16'd255};
		load_settings(1'b1);
		mains_runs(190);
		drain();

		// reversed extremes with off level zero
		setting = '{16'd127, 16'd0, 16'd1, 16'd3, 16'd0};
		load_settings(1'b0);
		mains_runs(190);
		drain();

		// fades down toward zero and back up to the default off level
		setting = '{16'd100, 16'd0, 16'd0, 16'd2, 16'd100};
		load_settings(1'b0);
		mains_runs(190);
		drain();

		// random register words, upper bits included, with short delays
		setting[0] = CFG_DATA_W'($urandom_range(0, 16'hFFFF));
		setting[1] = CFG_DATA_W'($urandom_range(0, 16'hFFFF));
		setting[2] = CFG_DATA_W'($urandom_range(0, 4));
		setting[3] = CFG_DATA_W'($urandom_range(0, 6));
		setting[4] = CFG_DATA_W'($urandom_range(0, 16'hFFFF));
		load_settings(1'b1);
		mains_runs(190);
		drain();

		// widest delay range: late steps when the delay pot swings low
		setting = '{16'd50, 16'd50, 16'hFFFF, 16'd0, 16'd255};
		load_settings(1'b0);
		mains_runs(180);
		drain();

		$display("covered %0d events: directed table plus five register settings",
			events_sent);
		$display("%0d words checked, %0d lamp firings, %0d cycles with input stalled",
			words_checked, lamp_fires, full_stalls);
		if (fail_count == 0 && pending_words.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
